@@ rtl/mcc_pkg.sv @@
// Shared types and constants for the minimum coin change block.
package mcc_pkg;

  localparam int unsigned CoinW      = 10;
  localparam int unsigned CountW     = 10;
  localparam int unsigned AmountW    = 10;
  localparam int unsigned NumCoinReg = 6;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CoinSelW   = 3;

  typedef logic [CfgIdxW-1:0]  cfg_idx_t;
  typedef logic [CoinSelW-1:0] coin_sel_t;

  localparam cfg_idx_t REG_COIN_COUNT = 3'd0;
  localparam cfg_idx_t REG_COIN_0     = 3'd1;

  localparam coin_sel_t     COIN_COUNT_RST = 3'd3;
  localparam logic [CoinW-1:0] COIN_RST [NumCoinReg] = '{
    10'd1, 10'd3, 10'd4, 10'd1, 10'd1, 10'd1
  };

  typedef struct packed {
    logic              reach;
    logic [CountW-1:0] count;
  } mcc_entry_t;

  localparam int unsigned EntryW = $bits(mcc_entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } mcc_state_e;

endpackage

@@ rtl/mcc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mcc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/min_coin_change_dp.sv @@
// Top level of the minimum coin change engine.
//
// Input channel: amount_i is transferred when in_valid_i is high and in_stall_o is low.
// Output channel: min_coins_o / unreachable_o transfer when out_valid_o is high and
// out_stall_i is low. unreachable_o = 1 means no coin mix forms the amount (count 0).
// Config: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 coin_count, 1..6 coins);
// write only while idle. Indexes past coin_5 are ignored.
// One query at a time: in_stall_o is high from the transfer until the result moves
// into the output register. Entries 1..amount of the count table are built in order,
// each from one step per coin (a table read, where the coin fits, through the single
// RAM read port) and then one write, used = min(coin_count, MAX_COINS).
// Amount 0 and amounts above MAX_AMOUNT skip the table build.
// A new amount can be taken while the previous result is still held by a stalled
// receiver; the finished result then waits until the output register frees up.
// Reset clears control and restores the default coins (1, 3, 4; count 3).
// The table needs no clearing pass: every entry read is written earlier in the query.
module min_coin_change_dp #(
  parameter int unsigned MAX_AMOUNT = 1023,
  parameter int unsigned MAX_COINS  = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [mcc_pkg::AmountW-1:0]   amount_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mcc_pkg::CountW-1:0]    min_coins_o,
  output logic                          unreachable_o,
  input  logic                          cfg_we_i,
  input  mcc_pkg::cfg_idx_t             cfg_idx_i,
  input  logic [mcc_pkg::CoinW-1:0]     cfg_data_i
);

  import mcc_pkg::*;

  localparam int unsigned Depth = MAX_AMOUNT + 1;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned CW    = (AW > CoinW) ? AW : CoinW;
  localparam logic [16:0] MaxAmt  = 17'(MAX_AMOUNT);
  localparam coin_sel_t   UsedMax = CoinSelW'(MAX_COINS);

  mcc_state_e state_q, state_d;

  coin_sel_t        coin_count_q;
  logic [CoinW-1:0] coin_q [NumCoinReg];

  logic [AW-1:0]     a_q, a_d, amt_q, amt_d;
  coin_sel_t         j_q, j_d;
  logic              ok_q, ok_d, pend_q, pend_d;
  logic [CountW:0]   best_q, best_d;
  logic              res_ok_q, res_ok_d;
  logic [CountW-1:0] res_cnt_q, res_cnt_d;
  logic              out_valid_q, out_unr_q;
  logic [CountW-1:0] out_cnt_q;
  logic              out_load;

  coin_sel_t        used;
  logic [CoinW-1:0] coin_sel;
  logic [CW-1:0]    coin_ext, a_ext, diff;
  logic             usable, take, ok_n;
  logic [CountW:0]  cand, best_n;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  mcc_entry_t    ram_wdata, ram_rdata;

  mcc_ram #(
    .Width (EntryW),
    .Depth (Depth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (diff[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coin_count_q <= COIN_COUNT_RST;
      for (int i = 0; i < NumCoinReg; i++) begin
        coin_q[i] <= COIN_RST[i];
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_COIN_COUNT) begin
        coin_count_q <= cfg_data_i[CoinSelW-1:0];
      end
      for (int i = 0; i < NumCoinReg; i++) begin
        if (cfg_idx_i == REG_COIN_0 + CfgIdxW'(i)) begin
          coin_q[i] <= cfg_data_i;
        end
      end
    end
  end

  assign used = (coin_count_q > UsedMax) ? UsedMax : coin_count_q;

  always_comb begin
    coin_sel = '0;
    for (int i = 0; i < NumCoinReg; i++) begin
      if (j_q == CoinSelW'(i)) begin
        coin_sel = coin_q[i];
      end
    end
  end

  // shared compare / subtract unit
  assign coin_ext = CW'(coin_sel);
  assign a_ext    = CW'(a_q);
  assign diff     = a_ext - coin_ext;
  assign usable   = (j_q < used) && (coin_sel != '0) && (coin_ext <= a_ext);

  assign cand   = {1'b0, ram_rdata.count} + (CountW + 1)'(1);
  assign take   = pend_q && ram_rdata.reach && (!ok_q || (cand < best_q));
  assign ok_n   = ok_q | take;
  assign best_n = take ? cand : best_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q       <= a_d;
    amt_q     <= amt_d;
    j_q       <= j_d;
    ok_q      <= ok_d;
    best_q    <= best_d;
    res_ok_q  <= res_ok_d;
    res_cnt_q <= res_cnt_d;
  end

  always_comb begin
    state_d   = state_q;
    a_d       = a_q;
    amt_d     = amt_q;
    j_d       = j_q;
    ok_d      = ok_q;
    best_d    = best_q;
    pend_d    = 1'b0;
    res_ok_d  = res_ok_q;
    res_cnt_d = res_cnt_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ram_we          = 1'b1;
          ram_wdata.reach = 1'b1;
          a_d             = AW'(1);
          amt_d           = AW'(amount_i);
          j_d             = '0;
          ok_d            = 1'b0;
          best_d          = '0;
          res_cnt_d       = '0;
          if (17'(amount_i) > MaxAmt) begin
            res_ok_d = 1'b0;
            state_d  = ST_DONE;
          end else if (amount_i == '0) begin
            res_ok_d = 1'b1;
            state_d  = ST_DONE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (j_q == used) begin
          ram_we          = 1'b1;
          ram_waddr       = a_q;
          ram_wdata.reach = ok_n;
          ram_wdata.count = ok_n ? best_n[CountW-1:0] : '0;
          res_ok_d        = ok_n;
          res_cnt_d       = ok_n ? best_n[CountW-1:0] : '0;
          j_d             = '0;
          ok_d            = 1'b0;
          best_d          = '0;
          if (a_q == amt_q) begin
            state_d = ST_DONE;
          end else begin
            a_d = a_q + AW'(1);
          end
        end else begin
          ram_re = usable;
          pend_d = usable;
          ok_d   = ok_n;
          best_d = best_n;
          j_d    = j_q + CoinSelW'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_cnt_q <= res_cnt_q;
      out_unr_q <= !res_ok_q;
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign min_coins_o   = out_cnt_q;
  assign unreachable_o = out_unr_q;

endmodule

@@ rtl/mcc_checker.sv @@
// Port-level checks for the minimum coin change engine, bound to the top level.
module mcc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [mcc_pkg::CountW-1:0]  min_coins_o,
  input logic                        unreachable_o
);

  a_unreach_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && unreachable_o |-> min_coins_o == '0)
    else $error("unreachable result with nonzero count");

  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after transfer");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a query in work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(min_coins_o) && $stable(unreachable_o))
    else $error("stalled result changed");

endmodule

bind min_coin_change_dp mcc_checker u_mcc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .min_coins_o   (min_coins_o),
  .unreachable_o (unreachable_o)
);

@@ bench/tb.sv @@
// Self-checking testbench for min_coin_change_dp: directed table, random queries, config sweeps.
`timescale 1ns / 100ps

module tb;
  import mcc_pkg::*;

  localparam int unsigned MaxCoins  = 6;
  localparam int unsigned TableSize = 1 << AmountW;
  localparam int unsigned IdlePause = 8;
  localparam int unsigned LongHold  = 600;
  localparam cfg_idx_t    REG_SPARE = cfg_idx_t'(REG_COIN_0 + NumCoinReg);

  typedef logic [AmountW-1:0] amount_t;
  typedef logic [CoinW-1:0]   coin_t;

  typedef struct packed {
    logic [CountW-1:0] min_coins;
    logic              unreachable;
  } change_t;

  typedef enum logic {ROW_WRITE, ROW_QUERY} row_kind_e;

  typedef struct packed {
    row_kind_e kind;
    cfg_idx_t  idx;
    coin_t     val;
    logic      typed;
    change_t   exp;
  } step_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  amount_t           amount_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [CountW-1:0] min_coins_o;
  logic              unreachable_o;
  logic              cfg_we_i = 1'b0;
  cfg_idx_t          cfg_idx_i = REG_COIN_COUNT;
  coin_t             cfg_data_i = '0;

  logic [CoinSelW-1:0] coin_count_q;
  coin_t               coin_val_q [NumCoinReg];

  change_t     pending_change_q [$];
  step_t       directed_rows [$];
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned checked_cnt = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned settings_cnt = 0;
  logic        hold_tog = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_left = 0;

  min_coin_change_dp DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .amount_i     (amount_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .min_coins_o  (min_coins_o),
    .unreachable_o(unreachable_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  function automatic change_t fewest_coins(input amount_t amt);
    logic [CountW-1:0] best_cnt [TableSize];
    logic              reach [TableSize];
    int unsigned       used;
    int unsigned       best;
    int unsigned       c;
    logic              ok;
    change_t           r;
    used = (32'(coin_count_q) > MaxCoins) ? MaxCoins : 32'(coin_count_q);
    best_cnt[0] = '0;
    reach[0] = 1'b1;
    for (int unsigned a = 1; a <= amt; a++) begin
      ok = 1'b0;
      best = 0;
      for (int unsigned j = 0; j < used; j++) begin
        c = 32'(coin_val_q[j]);
        if (c != 0 && c <= a) begin
          if (reach[a-c]) begin
            if (!ok || int'(best_cnt[a-c]) + 1 < best) begin
              best = int'(best_cnt[a-c]) + 1;
              ok = 1'b1;
            end
          end
        end
      end
      reach[a] = ok;
      best_cnt[a] = ok ? best[CountW-1:0] : '0;
    end
    if (reach[amt]) begin
      r.min_coins = best_cnt[amt];
      r.unreachable = 1'b0;
    end else begin
      r.min_coins = '0;
      r.unreachable = 1'b1;
    end
    return r;
  endfunction

  function automatic step_t cfg_row(input cfg_idx_t idx, input coin_t val);
    return '{ROW_WRITE, idx, val, 1'b0, change_t'(0)};
  endfunction

  function automatic step_t query_typed(input amount_t amt, input int unsigned cnt,
                                        input logic unr);
    change_t e;
    e.min_coins = cnt[CountW-1:0];
    e.unreachable = unr;
    return '{ROW_QUERY, REG_COIN_COUNT, amt, 1'b1, e};
  endfunction

  function automatic step_t query_pred(input amount_t amt);
    return '{ROW_QUERY, REG_COIN_COUNT, amt, 1'b0, change_t'(0)};
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input coin_t val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_COIN_COUNT) begin
      coin_count_q = val[CoinSelW-1:0];
    end else if (idx >= REG_COIN_0 && idx < REG_SPARE) begin
      coin_val_q[idx - REG_COIN_0] = val;
    end
    @(posedge clk_i);
  endtask

  task automatic send_amount(input amount_t amt, input change_t exp);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    amount_i <= amt;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_change_q = {pending_change_q, exp};
  endtask

  task automatic settle_block();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_change_q.size() != 0) @(posedge clk_i);
    repeat (IdlePause) @(posedge clk_i);
  endtask

  task automatic randomize_coins();
    coin_t v;
    settle_block();
    v = ($urandom_range(7) == 0) ? coin_t'($urandom_range(1) * 7) : coin_t'($urandom_range(1, 6));
    write_reg(REG_COIN_COUNT, v);
    for (int unsigned j = 0; j < NumCoinReg; j++) begin
      case ($urandom_range(9))
        0:       v = '0;
        1:       v = coin_t'($urandom_range(1023));
        default: v = coin_t'($urandom_range(1, 12));
      endcase
      write_reg(cfg_idx_t'(REG_COIN_0 + j), v);
    end
    if ($urandom_range(3) == 0) write_reg(REG_SPARE, coin_t'($urandom));
    settings_cnt++;
  endtask

  task automatic random_amounts(input int unsigned n, input int unsigned span);
    amount_t amt;
    for (int unsigned i = 0; i < n; i++) begin
      amt = ($urandom_range(15) == 0) ? amount_t'($urandom) : amount_t'($urandom_range(span));
      send_amount(amt, fewest_coins(amt));
    end
  endtask

  // receiver: random stall, or a long counted hold on request
  always @(posedge clk_i) begin
    if (hold_tog != hold_seen) begin
      hold_seen = hold_tog;
      hold_left = LongHold;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    change_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_change_q.size() == 0) begin
        $error("result transfer with nothing pending: min_coins %0d unreachable %0b",
               min_coins_o, unreachable_o);
        mismatch_cnt++;
      end else begin
        e = pending_change_q.pop_front();
        checked_cnt++;
        if (min_coins_o !== e.min_coins) begin
          $error("min_coins: expected %0d, got %0d", e.min_coins, min_coins_o);
          mismatch_cnt++;
        end
        if (unreachable_o !== e.unreachable) begin
          $error("unreachable: expected %0b, got %0b", e.unreachable, unreachable_o);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("** min_coin_change_dp: FAILED **");
    $finish;
  end

  initial begin
    int unsigned src_mix [4];
    int unsigned sink_mix [4];
    src_mix = '{0, 60, 0, 18};
    sink_mix = '{0, 0, 60, 18};

    coin_count_q = COIN_COUNT_RST;
    for (int unsigned j = 0; j < NumCoinReg; j++) coin_val_q[j] = COIN_RST[j];

    directed_rows = {
      query_typed(0, 0, 1'b0), query_typed(1, 1, 1'b0), query_typed(4, 1, 1'b0),
      query_typed(6, 2, 1'b0), query_typed(2, 2, 1'b0), query_pred(1023), query_pred(512),
      // no coins: only zero is reachable
      cfg_row(REG_COIN_COUNT, 0),
      query_typed(0, 0, 1'b0), query_typed(5, 0, 1'b1),
      cfg_row(REG_COIN_COUNT, 1), cfg_row(REG_COIN_0, 1023),
      query_typed(1023, 1, 1'b0), query_typed(1022, 0, 1'b1),
      // zero-valued coin contributes nothing
      cfg_row(REG_COIN_COUNT, 2), cfg_row(REG_COIN_0, 0),
      cfg_row(cfg_idx_t'(REG_COIN_0 + 1), 2),
      query_typed(7, 0, 1'b1), query_typed(8, 4, 1'b0),
      cfg_row(REG_SPARE, 1),
      query_typed(9, 0, 1'b1),
      // count 7 saturates to six coins; only coin_5 makes small amounts
      cfg_row(REG_COIN_COUNT, 7), cfg_row(REG_COIN_0, 1023),
      cfg_row(cfg_idx_t'(REG_COIN_0 + 1), 512), cfg_row(cfg_idx_t'(REG_COIN_0 + 2), 256),
      cfg_row(cfg_idx_t'(REG_COIN_0 + 3), 100), cfg_row(cfg_idx_t'(REG_COIN_0 + 4), 10),
      cfg_row(cfg_idx_t'(REG_COIN_0 + 5), 3),
      query_typed(3, 1, 1'b0), query_typed(6, 2, 1'b0), query_typed(1, 0, 1'b1),
      query_typed(1023, 1, 1'b0), query_pred(1021)
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    settings_cnt = 1;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        settle_block();
        write_reg(directed_rows[i].idx, directed_rows[i].val);
        if (directed_rows[i].idx == REG_COIN_COUNT) settings_cnt++;
      end else if (directed_rows[i].typed) begin
        send_amount(directed_rows[i].val, directed_rows[i].exp);
      end else begin
        send_amount(directed_rows[i].val, fewest_coins(directed_rows[i].val));
      end
    end

    for (int unsigned p = 0; p < 4; p++) begin
      randomize_coins();
      src_idle_pct = src_mix[p];
      sink_stall_pct = sink_mix[p];
      random_amounts(20, 80);
    end

    randomize_coins();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    hold_tog <= ~hold_tog;
    random_amounts(8, 15);

    settle_block();
    repeat (50) @(posedge clk_i);

    $display("%0d results checked over %0d coin settings", checked_cnt, settings_cnt);
    $display("covered: zero/saturated counts, zero coins, handshake mixes, long output hold");
    if (mismatch_cnt == 0) begin
      $display("** min_coin_change_dp: PASSED **");
    end else begin
      $display("** min_coin_change_dp: FAILED **");
    end
    $finish;
  end

endmodule
